### src/assert_macros.svh
// assertion macros used by great_circle_distance
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define ASSERT_AR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/gcd_pkg.sv
// shared widths, constants and the arctangent table of the distance pipeline
// no dependencies
package gcd_pkg;

	// datapath widths
	localparam int AW = 36;
	localparam int XW = 34;
	localparam int ZW = 33;
	localparam int SQW = 62;
	localparam int SQ_STEPS = 31;
	localparam int RAD_W = 16;
	localparam int OUT_W = 18;

	// fixed point constants, Q30; DIST_MAX and RADIUS_RESET are plain integers
	localparam logic signed [AW-1:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [AW-1:0] TWO_PI_Q30 = 36'sd6746518852;
	localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [25:0] DEG2RAD_Q30 = 26'sd18740330;
	localparam logic signed [XW-1:0] GAIN_INV_Q30 = 34'sd652032874;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [OUT_W-1:0] DIST_MAX = 18'd205888;
	localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd6378;

	// register index bit of the configuration port
	localparam logic REG_RADIUS = 1'b0;

	// atan(2^-i) in Q30
	function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0: r = 33'sd843314857;
			5'd1: r = 33'sd497837829;
			5'd2: r = 33'sd263043837;
			5'd3: r = 33'sd133525159;
			5'd4: r = 33'sd67021687;
			5'd5: r = 33'sd33543516;
			5'd6: r = 33'sd16775851;
			5'd7: r = 33'sd8388437;
			5'd8: r = 33'sd4194283;
			5'd9: r = 33'sd2097149;
			5'd10: r = 33'sd1048576;
			5'd11: r = 33'sd524288;
			5'd12: r = 33'sd262144;
			5'd13: r = 33'sd131072;
			5'd14: r = 33'sd65536;
			5'd15: r = 33'sd32768;
			5'd16: r = 33'sd16384;
			5'd17: r = 33'sd8192;
			5'd18: r = 33'sd4096;
			5'd19: r = 33'sd2048;
			5'd20: r = 33'sd1024;
			5'd21: r = 33'sd512;
			5'd22: r = 33'sd256;
			5'd23: r = 33'sd128;
			5'd24: r = 33'sd64;
			5'd25: r = 33'sd32;
			5'd26: r = 33'sd16;
			5'd27: r = 33'sd8;
			5'd28: r = 33'sd4;
			5'd29: r = 33'sd2;
			5'd30: r = 33'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// bring an angle into [-pi, pi]
	function automatic logic signed [AW-1:0] wrap_pi(input logic signed [AW-1:0] z);
		logic signed [AW-1:0] r;
		r = z;
		if (z > PI_Q30) r = z - TWO_PI_Q30;
		else if (z < -PI_Q30) r = z + TWO_PI_Q30;
		return r;
	endfunction

endpackage

### src/gcd_cordic_cell.sv
// one CORDIC micro-rotation, rotation or vectoring mode, registered
// depends on gcd_pkg
module gcd_cordic_cell import gcd_pkg::*; #(
	parameter int IDX = 0,
	parameter bit VECTOR = 1'b0
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [XW-1:0]  x_in,
	input  logic signed [XW-1:0]  y_in,
	input  logic signed [ZW-1:0]  z_in,
	output logic signed [XW-1:0]  x_q,
	output logic signed [XW-1:0]  y_q,
	output logic signed [ZW-1:0]  z_q
);

	logic signed [XW-1:0] xs, ys;
	logic signed [ZW-1:0] ang;
	logic                 pos;

	// shifted terms and direction
	assign xs  = x_in >>> IDX;
	assign ys  = y_in >>> IDX;
	assign ang = atan_q30(5'(IDX));
	assign pos = VECTOR ? (y_in[XW-1] || (y_in == '0)) : !z_in[ZW-1];

	// rotate by +-atan(2^-i)
	always_ff @(posedge clk) begin
		if (en) begin
			if (pos) begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - ang;
			end else begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + ang;
			end
		end
	end

endmodule

### src/gcd_sqrt_cell.sv
// one step of the digit-by-digit square root, one result bit per cell
// depends on gcd_pkg
module gcd_sqrt_cell import gcd_pkg::*; #(
	parameter int K = 0
) (
	input  logic            clk,
	input  logic            en,
	input  logic [SQW-1:0]  v_in,
	input  logic [SQW-1:0]  r_in,
	output logic [SQW-1:0]  v_q,
	output logic [SQW-1:0]  r_q
);

	localparam int SQ_TOP = 2 * (SQ_STEPS - 1);
	localparam logic [SQW-1:0] BIT = SQW'(1) << (SQ_TOP - 2 * K);

	logic [SQW-1:0] trial;

	assign trial = r_in + BIT;

	// trial subtract, keep or restore
	always_ff @(posedge clk) begin
		if (en) begin
			if (v_in >= trial) begin
				v_q <= v_in - trial;
				r_q <= (r_in >> 1) + BIT;
			end else begin
				v_q <= v_in;
				r_q <= r_in >> 1;
			end
		end
	end

endmodule

### src/great_circle_distance.sv
// haversine great-circle distance, one point pair per item
// throughput one item per cycle while the skid is empty, set by the fully unrolled cordic and root chains
// the whole pipeline halts while the skid holds an item, which fills only when an item
// reaches a stalled output register
// reset clears valid bits and the skid; radius_q resets to 6378
`include "assert_macros.svh"
module great_circle_distance import gcd_pkg::*; #(
	parameter int CORDIC_STAGES = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [23:0]  first_latitude,
	input  logic signed [24:0]  first_longitude,
	input  logic signed [23:0]  second_latitude,
	input  logic signed [24:0]  second_longitude,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [OUT_W-1:0]    distance
);

	localparam int N = CORDIC_STAGES;
	localparam int LAT = 4 + N + 2 + SQ_STEPS + N + 2;

	logic [RAD_W-1:0] radius_q;
	logic             en;
	logic [LAT-1:0]   vld_q;
	logic             skid_valid_q, out_valid_q;
	logic [OUT_W-1:0] skid_q, dist_q;
	logic             take_in, incoming;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RADIUS) ? {16'b0, radius_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_RADIUS) begin
			radius_q <= pwdata[RAD_W-1:0];
		end
	end

	// pipeline advance and valid line
	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;
	assign take_in  = in_valid && en;
	assign incoming = en && vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], take_in};
		end
	end

	// stage 1: differences
	logic signed [23:0] lat1_s1, lat2_s1;
	logic signed [24:0] dlat_s1;
	logic signed [25:0] dlon_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			lat1_s1 <= first_latitude;
			lat2_s1 <= second_latitude;
			dlat_s1 <= 25'(second_latitude) - 25'(first_latitude);
			dlon_s1 <= 26'(second_longitude) - 26'(first_longitude);
		end
	end

	// stage 2: degrees to radians
	logic signed [51:0] m_dlat, m_dlon, m_lat1, m_lat2;
	logic signed [AW-1:0] ang_s2 [4];
	logic signed [AW-1:0] ang_s3 [4];

	assign m_dlat = 52'(dlat_s1) * 52'(DEG2RAD_Q30);
	assign m_dlon = 52'(dlon_s1) * 52'(DEG2RAD_Q30);
	assign m_lat1 = 52'(lat1_s1) * 52'(DEG2RAD_Q30);
	assign m_lat2 = 52'(lat2_s1) * 52'(DEG2RAD_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s2[0] <= AW'(m_dlat >>> 17);
			ang_s2[1] <= AW'(m_dlon >>> 17);
			ang_s2[2] <= AW'(m_lat1 >>> 16);
			ang_s2[3] <= AW'(m_lat2 >>> 16);
		end
	end

	// stage 3: wrap into [-pi, pi]
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) ang_s3[k] <= wrap_pi(ang_s2[k]);
		end
	end

	// stage 4: fold into [-pi/2, pi/2], remember the sign flip
	logic signed [ZW-1:0] fz [4];
	logic [3:0]           fn;
	logic signed [ZW-1:0] ang_s4 [4];
	logic [1:0]           neg_s4;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			fz[k] = ZW'(ang_s3[k]);
			fn[k] = 1'b0;
			if (ang_s3[k] > HALF_PI_Q30) begin
				fz[k] = ZW'(ang_s3[k] - PI_Q30);
				fn[k] = 1'b1;
			end else if (ang_s3[k] < -HALF_PI_Q30) begin
				fz[k] = ZW'(ang_s3[k] + PI_Q30);
				fn[k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) ang_s4[k] <= fz[k];
			neg_s4 <= fn[3:2];
		end
	end

	// sine/cosine chains: half dlat, half dlon, lat1, lat2
	logic signed [XW-1:0] rx [4][N+1];
	logic signed [XW-1:0] ry [4][N+1];
	logic signed [ZW-1:0] rz [4][N+1];

	for (genvar k = 0; k < 4; k++) begin : g_rot
		assign rx[k][0] = GAIN_INV_Q30;
		assign ry[k][0] = '0;
		assign rz[k][0] = ang_s4[k];
		for (genvar i = 0; i < N; i++) begin : g_cell
			gcd_cordic_cell #(.IDX(i), .VECTOR(1'b0)) u_cell (
				.clk  (clk),
				.en   (en),
				.x_in (rx[k][i]),
				.y_in (ry[k][i]),
				.z_in (rz[k][i]),
				.x_q  (rx[k][i+1]),
				.y_q  (ry[k][i+1]),
				.z_q  (rz[k][i+1])
			);
		end
	end

	// cosine sign flips follow the rotation chain
	logic [1:0] neg_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			neg_q[0] <= neg_s4;
			for (int i = 1; i < N; i++) neg_q[i] <= neg_q[i-1];
		end
	end

	// stage 5: squares and cosine product
	logic signed [31:0] ylat, ylon, c1, c2;
	logic signed [63:0] p_lat, p_lon, p_cc;
	logic signed [32:0] sl2_s5, so2_s5, cc_s5;

	assign ylat  = 32'(ry[0][N]);
	assign ylon  = 32'(ry[1][N]);
	assign c1    = neg_q[N-1][0] ? -32'(rx[2][N]) : 32'(rx[2][N]);
	assign c2    = neg_q[N-1][1] ? -32'(rx[3][N]) : 32'(rx[3][N]);
	assign p_lat = ylat * ylat;
	assign p_lon = ylon * ylon;
	assign p_cc  = c1 * c2;

	always_ff @(posedge clk) begin
		if (en) begin
			sl2_s5 <= 33'(p_lat >>> 30);
			so2_s5 <= 33'(p_lon >>> 30);
			cc_s5  <= 33'(p_cc >>> 30);
		end
	end

	// stage 6: haversine term, clamped to [0, 1]
	logic signed [65:0] p_t;
	logic signed [36:0] a_sum;
	logic [30:0]        a_s6, b_s6;

	assign p_t   = cc_s5 * so2_s5;
	assign a_sum = 37'(sl2_s5) + 37'(p_t >>> 30);

	always_ff @(posedge clk) begin
		if (en) begin
			if (a_sum[36]) begin
				a_s6 <= '0;
				b_s6 <= ONE_Q30;
			end else if (a_sum > $signed({6'b0, ONE_Q30})) begin
				a_s6 <= ONE_Q30;
				b_s6 <= '0;
			end else begin
				a_s6 <= a_sum[30:0];
				b_s6 <= ONE_Q30 - a_sum[30:0];
			end
		end
	end

	// square root chains of a and 1-a
	logic [SQW-1:0] sv [2][SQ_STEPS+1];
	logic [SQW-1:0] sr [2][SQ_STEPS+1];

	assign sv[0][0] = {1'b0, a_s6, 30'b0};
	assign sv[1][0] = {1'b0, b_s6, 30'b0};

	for (genvar j = 0; j < 2; j++) begin : g_sqrt
		assign sr[j][0] = '0;
		for (genvar i = 0; i < SQ_STEPS; i++) begin : g_cell
			gcd_sqrt_cell #(.K(i)) u_cell (
				.clk  (clk),
				.en   (en),
				.v_in (sv[j][i]),
				.r_in (sr[j][i]),
				.v_q  (sv[j][i+1]),
				.r_q  (sr[j][i+1])
			);
		end
	end

	// central angle by vectoring
	logic signed [XW-1:0] vx [N+1];
	logic signed [XW-1:0] vy [N+1];
	logic signed [ZW-1:0] vz [N+1];

	assign vx[0] = $signed({3'b0, sr[1][SQ_STEPS][30:0]});
	assign vy[0] = $signed({3'b0, sr[0][SQ_STEPS][30:0]});
	assign vz[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_vec
		gcd_cordic_cell #(.IDX(i), .VECTOR(1'b1)) u_cell (
			.clk  (clk),
			.en   (en),
			.x_in (vx[i]),
			.y_in (vy[i]),
			.z_in (vz[i]),
			.x_q  (vx[i+1]),
			.y_q  (vy[i+1]),
			.z_q  (vz[i+1])
		);
	end

	// stage 7: clamp angle, scale by radius
	logic [30:0] zc;
	logic [46:0] prod_s7;

	always_comb begin
		zc = vz[N][30:0];
		if (vz[N][ZW-1]) zc = '0;
		else if (vz[N] > HALF_PI_Q30) zc = HALF_PI_Q30[30:0];
	end

	always_ff @(posedge clk) begin
		if (en) prod_s7 <= radius_q * zc;
	end

	// stage 8: round half up, saturate
	logic [47:0]      rsum;
	logic [18:0]      dround;
	logic [OUT_W-1:0] dist_s8;

	assign rsum   = {1'b0, prod_s7} + (48'd1 << 28);
	assign dround = rsum[47:29];

	always_ff @(posedge clk) begin
		if (en) dist_s8 <= (dround > 19'(DIST_MAX)) ? DIST_MAX : dround[OUT_W-1:0];
	end

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (!out_valid_q || !out_stall) begin
				skid_valid_q <= 1'b0;
				out_valid_q  <= 1'b1;
			end
		end else begin
			out_valid_q <= incoming || (out_valid_q && out_stall);
			if (incoming && out_valid_q && out_stall) skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!out_valid_q || !out_stall) dist_q <= skid_q;
		end else if (incoming) begin
			if (out_valid_q && out_stall) skid_q <= dist_s8;
			else dist_q <= dist_s8;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = dist_q;

	// checks
	`ASSERT_ALWAYS(a_skid_needs_out, (!arst_n || !skid_valid_q || out_valid_q), "skid holds an item while output empty")
	`ASSERT_AR(a_dist_range, (out_valid_q |-> (distance <= DIST_MAX)), "distance above saturation limit")
	`ASSERT_AR(a_skid_fill, ($rose(skid_valid_q) |-> $past(out_valid_q && out_stall)), "skid filled without a stalled output")

endmodule
